FILE: rtl/humidity_sensor_edge_decoder_macros.svh
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder assertion macros
// Shared assertion forms for the decoder's checker. The including module
// must provide signals named clk and rst.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_EDGE_DECODER_MACROS_SVH
`define HUMIDITY_SENSOR_EDGE_DECODER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define HSED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HSED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hsed_pkg.sv
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder package
// Widths, reset values, item kind codes and the control word shared by the
// decoder's modules.
// ----------------------------------------------------------------------------
package hsed_pkg;

  // Width of the free-running tick counter and of the edge interval.
  localparam int TIME_BITS = 16;

  // Width of one sensor frame: four data bytes and a checksum byte.
  localparam int FRAME_BITS = 40;

  // Width of the threshold register and the data fields.
  localparam int DATA_BITS = 16;

  // Reset value of the bit threshold, in ticks.
  localparam logic [DATA_BITS-1:0] THRESHOLD_RESET = 16'd12;

  // Inverts the magnitude of a negative sign-magnitude temperature.
  localparam logic [DATA_BITS-1:0] SIGN_FIX_MASK = 16'h7FFF;

  // Item kind codes.
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // Per-cycle strobes from the input handshake to the datapath.
  typedef struct packed {
    logic take_edge;
    logic take_eval;
  } hsed_ctl_t;

endpackage

FILE: rtl/hsed_frame.sv
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder frame shifter
// Measures the wrapping interval between falling edges and shifts one frame
// bit per edge into a 40-bit register, newest bit at bit 0.
// ----------------------------------------------------------------------------
module hsed_frame import hsed_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  hsed_ctl_t             ctl,
  input  logic [TIME_BITS-1:0]  edge_time,
  input  logic [DATA_BITS-1:0]  bit_threshold,
  output logic [FRAME_BITS-1:0] frame_bits
);

  logic [TIME_BITS-1:0] last_edge_time;
  logic [TIME_BITS-1:0] interval;
  logic                 new_bit;

  // Interval since the previous edge, modulo the counter width.
  assign interval = edge_time - last_edge_time;
  assign new_bit  = (interval > bit_threshold);

  // Edge timestamp and frame shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      frame_bits     <= '0;
    end else if (ctl.take_edge) begin
      last_edge_time <= edge_time;
      frame_bits     <= {frame_bits[FRAME_BITS-2:0], new_bit};
    end
  end

endmodule

FILE: rtl/hsed_eval.sv
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder frame evaluator
// Checks the frame checksum, converts the temperature to two's complement,
// holds the last good readings and registers the result word.
// ----------------------------------------------------------------------------
module hsed_eval import hsed_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  hsed_ctl_t             ctl,
  input  logic [FRAME_BITS-1:0] frame_bits,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  checksum_ok,
  output logic signed [DATA_BITS-1:0] temperature,
  output logic [DATA_BITS-1:0]  humidity
);

  logic [9:0]           byte_sum;
  logic                 match;
  logic [DATA_BITS-1:0] raw_temp;
  logic [DATA_BITS-1:0] conv_temp;
  logic [DATA_BITS-1:0] held_temperature;
  logic [DATA_BITS-1:0] held_humidity;
  logic [DATA_BITS-1:0] temp_next;
  logic [DATA_BITS-1:0] hum_next;

  // Sum of the four data bytes against the checksum byte.
  assign byte_sum = {2'b00, frame_bits[15:8]}  + {2'b00, frame_bits[23:16]}
                  + {2'b00, frame_bits[31:24]} + {2'b00, frame_bits[39:32]};
  assign match    = (byte_sum[7:0] == frame_bits[7:0]);

  // Sign-magnitude to two's complement; negative zero wraps to zero.
  assign raw_temp  = frame_bits[23:8];
  assign conv_temp = raw_temp[DATA_BITS-1] ? ((raw_temp ^ SIGN_FIX_MASK) + 16'd1)
                                           : raw_temp;

  // Values reported for this evaluation.
  assign temp_next = match ? conv_temp : held_temperature;
  assign hum_next  = match ? frame_bits[39:24] : held_humidity;

  // Held readings, updated only on a good checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_humidity    <= '0;
    end else if (ctl.take_eval && match) begin
      held_temperature <= conv_temp;
      held_humidity    <= frame_bits[39:24];
    end
  end

  // Result register: valid is set by an evaluation and cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take_eval) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, loaded only when a new word is formed.
  always_ff @(posedge clk) begin
    if (ctl.take_eval) begin
      checksum_ok <= match;
      temperature <= temp_next;
      humidity    <= hum_next;
    end
  end

endmodule

FILE: rtl/humidity_sensor_edge_decoder.sv
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder
// Decodes a single-wire temperature and humidity sensor frame from falling
// edge timestamps and reports checked readings.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per item. kind selects a
// falling edge (edge_time is the tick count at the edge) or an evaluation.
// Edge words update the frame and produce no output word.
// Output channel (out_valid / out_stall): one word per evaluation carrying
// checksum_ok, temperature and humidity. It appears in the cycle after the
// evaluation is accepted.
// Throughput is one input word per cycle when not stalled; each word is
// handled in a single pass from the input port to the result register.
// The input stalls only while an output word is waiting and out_stall is
// high; a waiting word and its fields hold until taken.
// Configuration (cfg_valid / cfg_ready): cfg_data writes bit_threshold. The
// port is always ready and should be written only while the block is idle.
// Reset clears the frame, the edge timestamp, the held readings and the
// output valid, and sets bit_threshold to 12.
// ----------------------------------------------------------------------------
module humidity_sensor_edge_decoder import hsed_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [TIME_BITS-1:0]        edge_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        checksum_ok,
  output logic signed [DATA_BITS-1:0] temperature,
  output logic [DATA_BITS-1:0]        humidity,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [DATA_BITS-1:0]        cfg_data
);

  logic [DATA_BITS-1:0]  bit_threshold;
  logic [FRAME_BITS-1:0] frame_bits;
  logic                  in_accept;
  hsed_ctl_t             ctl;

  // Input handshake: hold off only while a result word is blocked.
  assign in_stall      = out_valid && out_stall;
  assign in_accept     = in_valid && !in_stall;
  assign ctl.take_edge = in_accept && (kind == KIND_EDGE);
  assign ctl.take_eval = in_accept && (kind == KIND_EVAL);

  // Threshold register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bit_threshold <= cfg_data;
    end
  end

  hsed_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .edge_time     (edge_time),
    .bit_threshold (bit_threshold),
    .frame_bits    (frame_bits)
  );

  hsed_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .frame_bits  (frame_bits),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .checksum_ok (checksum_ok),
    .temperature (temperature),
    .humidity    (humidity)
  );

endmodule

FILE: rtl/hsed_checker.sv
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder checker
// Port-level assertions on the decoder's handshakes and result timing,
// bound to the top level.
// ----------------------------------------------------------------------------
`include "humidity_sensor_edge_decoder_macros.svh"

module hsed_checker import hsed_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        checksum_ok,
  input logic signed [DATA_BITS-1:0] temperature,
  input logic [DATA_BITS-1:0]        humidity
);

  // A blocked result word stays valid and keeps its fields.
  `HSED_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(checksum_ok) && $stable(temperature) && $stable(humidity), "result word changed while stalled")

  // The input stalls whenever a result word is blocked.
  `HSED_ASSERT(a_in_stall, out_valid && out_stall |-> in_stall, "input accepted while output blocked")

  // An accepted evaluation gives a result word in the next cycle.
  `HSED_ASSERT(a_eval_result, in_valid && !in_stall && (kind == KIND_EVAL) |=> out_valid, "evaluation gave no result")

  // An accepted edge gives no result word.
  `HSED_ASSERT(a_edge_silent, in_valid && !in_stall && (kind == KIND_EDGE) |=> !out_valid, "edge gave a result")

  // No result word is shown while reset is applied.
  `HSED_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid after reset")

endmodule

bind humidity_sensor_edge_decoder hsed_checker u_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Humidity sensor edge decoder testbench
// Drives edge and evaluate words into the decoder with random idle cycles and
// output stalls. It builds sensor frames from timed edge intervals across
// several threshold settings. A frame decoder model in the scoreboard
// predicts every reading, and each reading the block delivers is checked
// against it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import hsed_pkg::*;

  // One reading as the block reports it.
  typedef struct {
    logic                        ok;
    logic signed [DATA_BITS-1:0] temp;
    logic [DATA_BITS-1:0]        hum;
  } reading_t;

  // Frame decoder model and the readings it still expects.
  class reading_scoreboard;
    logic [DATA_BITS-1:0]  threshold = THRESHOLD_RESET;
    logic [TIME_BITS-1:0]  last_edge = '0;
    logic [FRAME_BITS-1:0] frame     = '0;
    logic [DATA_BITS-1:0]  held_temp = '0;
    logic [DATA_BITS-1:0]  held_hum  = '0;
    reading_t              due_readings[$];
    int                    errors    = 0;

    // Update the frame for an accepted edge word, or predict a reading for
    // an accepted evaluate word.
    function void take_word(logic k, logic [TIME_BITS-1:0] t);
      logic [TIME_BITS-1:0] gap;
      logic [7:0]           sum;
      logic [DATA_BITS-1:0] t_raw;
      reading_t             r;
      if (k == KIND_EDGE) begin
        gap = t - last_edge;
        frame = {frame[FRAME_BITS-2:0], gap > threshold};
        last_edge = t;
      end else begin
        sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
        r.ok = (sum == frame[7:0]);
        if (r.ok) begin
          // Sign-magnitude to two's complement; negative zero wraps to zero.
          t_raw = frame[23:8];
          if (t_raw[15]) begin
            t_raw = (t_raw ^ SIGN_FIX_MASK) + 16'd1;
          end
          held_temp = t_raw;
          held_hum = frame[39:24];
        end
        r.temp = held_temp;
        r.hum = held_hum;
        due_readings.push_back(r);
      end
    endfunction

    // Compare a delivered reading with the oldest prediction.
    function void check_reading(logic ok, logic signed [DATA_BITS-1:0] temp,
                                logic [DATA_BITS-1:0] hum);
      reading_t r;
      if (due_readings.size() == 0) begin
        $display("%0t: unexpected reading ok=%0b temp=%0d hum=%0d", $time, ok, temp, hum);
        errors++;
        return;
      end
      r = due_readings.pop_front();
      if (ok !== r.ok) begin
        $display("%0t: checksum_ok expected %0b actual %0b", $time, r.ok, ok);
        errors++;
      end
      if (temp !== r.temp) begin
        $display("%0t: temperature expected %0d actual %0d", $time, r.temp, temp);
        errors++;
      end
      if (hum !== r.hum) begin
        $display("%0t: humidity expected %0d actual %0d", $time, r.hum, hum);
        errors++;
      end
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic                        kind      = KIND_EDGE;
  logic [TIME_BITS-1:0]        edge_time = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        checksum_ok;
  logic signed [DATA_BITS-1:0] temperature;
  logic [DATA_BITS-1:0]        humidity;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [DATA_BITS-1:0]        cfg_data  = '0;

  reading_scoreboard    sb = new();
  logic                 no_idle = 1'b0;
  logic [TIME_BITS-1:0] tick_now = '0;
  int                   words_sent = 0;

  humidity_sensor_edge_decoder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .edge_time   (edge_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .checksum_ok (checksum_ok),
    .temperature (temperature),
    .humidity    (humidity),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver stalls at random, except during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 31);
  end

  // Check every reading taken from the output.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_reading(checksum_ok, temperature, humidity);
    end
  end

  // Send one word, with a random idle gap ahead of it. Starts and ends at a
  // falling edge.
  task send_word(input logic k, input logic [TIME_BITS-1:0] t);
    if (!no_idle && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    edge_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_word(k, t);
    words_sent++;
    @(negedge clk);
  endtask

  task send_edge_at(input logic [TIME_BITS-1:0] t);
    tick_now = t;
    send_word(KIND_EDGE, t);
  endtask

  // Pick an edge interval that decodes to the wanted bit under the current
  // threshold, mostly close to the boundary.
  function automatic logic [TIME_BITS-1:0] pick_interval(logic b);
    int unsigned thr;
    int unsigned lo;
    int unsigned hi;
    thr = 32'(sb.threshold);
    if (b) begin
      if (thr == 32'hFFFF) return TIME_BITS'($urandom);
      lo = thr + 1;
      hi = (65535 - lo > 300) ? lo + 300 : 65535;
      if ($urandom_range(0, 9) == 0) hi = 65535;
    end else begin
      hi = thr;
      lo = (thr > 300) ? thr - 300 : 0;
      if ($urandom_range(0, 9) == 0) lo = 0;
    end
    return TIME_BITS'($urandom_range(lo, hi));
  endfunction

  // Send the top nbits of a frame as edges, newest bit last.
  task send_bits(input logic [FRAME_BITS-1:0] f, input int nbits);
    for (int i = FRAME_BITS - 1; i >= FRAME_BITS - nbits; i--) begin
      send_edge_at(tick_now + pick_interval(f[i]));
    end
  endtask

  // Build a frame from humidity and raw temperature, optionally with a broken
  // checksum, send it and ask for a reading.
  task send_frame(input logic [15:0] hum, input logic [15:0] traw, input logic corrupt);
    logic [7:0] cs;
    cs = hum[15:8] + hum[7:0] + traw[15:8] + traw[7:0];
    if (corrupt) cs = cs ^ (8'd1 << $urandom_range(0, 7));
    send_bits({hum, traw, cs}, FRAME_BITS);
    send_word(KIND_EVAL, TIME_BITS'($urandom));
  endtask

  // Wait until the block is idle, then write the threshold.
  task write_threshold(input logic [DATA_BITS-1:0] v);
    in_valid <= 1'b0;
    while (sb.due_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.threshold = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_temp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return {1'b1, 15'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_hum();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames, some noise edges, partial frames and bare
  // evaluations, until the phase's word count is reached.
  task random_phase(input int count);
    int sel;
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        send_frame(pick_hum(), pick_temp(), $urandom_range(0, 4) == 0);
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 8)) send_edge_at(TIME_BITS'($urandom));
      end else if (sel < 92) begin
        send_bits(FRAME_BITS'({$urandom, $urandom}), $urandom_range(1, FRAME_BITS - 1));
        send_word(KIND_EVAL, TIME_BITS'($urandom));
      end else begin
        send_word(KIND_EVAL, TIME_BITS'($urandom));
      end
    end
  endtask

  // Main sequence.
  initial begin
    logic [DATA_BITS-1:0] thresholds[5];
    thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd300};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset threshold.
    send_word(KIND_EVAL, 16'h0000);
    send_edge_at(16'h0000);
    send_edge_at(16'h000C);
    send_edge_at(16'h0019);
    send_edge_at(16'hFFFF);
    send_edge_at(16'h0003);
    send_edge_at(16'h0003);
    send_edge_at(16'h8003);
    send_word(KIND_EVAL, 16'hFFFF);
    send_word(KIND_EVAL, 16'h0000);

    // Reset threshold, with one pause until every reading is in.
    random_phase(130);
    in_valid <= 1'b0;
    while (sb.due_readings.size() != 0) @(posedge clk);
    @(negedge clk);
    random_phase(130);

    foreach (thresholds[p]) begin
      write_threshold(thresholds[p]);
      no_idle = (p == 2);
      random_phase(270);
      no_idle = 1'b0;
    end

    in_valid <= 1'b0;
    while (sb.due_readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hsed_pkg.sv
rtl/hsed_frame.sv
rtl/hsed_eval.sv
rtl/humidity_sensor_edge_decoder.sv
rtl/hsed_checker.sv
sim/testbench.sv
